// File: design/mfa_pkg.sv
package mfa_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int RES_BITS = 48;
   localparam int WIDE_BITS = 64;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_GCD = 3'd4,
      OP_LCM = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_ZERO   = 2'd1,
      ERR_OPCODE = 2'd2
   } err_type;

   typedef struct packed {
      logic [2:0]                    opcode;
      logic signed [OPERAND_BITS-1:0] whole_a;
      logic signed [OPERAND_BITS-1:0] numer_a;
      logic signed [OPERAND_BITS-1:0] denom_a;
      logic signed [OPERAND_BITS-1:0] whole_b;
      logic signed [OPERAND_BITS-1:0] numer_b;
      logic signed [OPERAND_BITS-1:0] denom_b;
   } req_type;

   typedef struct packed {
      logic signed [RES_BITS-1:0] result_whole;
      logic signed [RES_BITS-1:0] result_numer;
      logic signed [RES_BITS-1:0] result_denom;
      logic [1:0]                 error_code;
   } rsp_type;

   // shared divider command/status
   typedef struct packed {
      logic                   start;
      logic [WIDE_BITS-1:0]   dividend;
      logic [WIDE_BITS-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                   done;
      logic [WIDE_BITS-1:0]   quot;
      logic [WIDE_BITS-1:0]   rem;
   } div_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_IMPA,
      ST_IMPB,
      ST_X1,
      ST_X2,
      ST_X3,
      ST_X4,
      ST_CHECK,
      ST_GCD_INIT,
      ST_GCD_DIV,
      ST_GCD_WAIT,
      ST_WHOLE_DIV,
      ST_WHOLE_WAIT,
      ST_WHOLE_FIX,
      ST_RED_DIV2,
      ST_RED_WAIT2,
      ST_LCM_MUL,
      ST_LCM_DIV,
      ST_LCM_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      GR_GCD,
      GR_LCM,
      GR_RED
   } gret_type;

   function automatic logic [WIDE_BITS-1:0] mag64(input logic [WIDE_BITS-1:0] v);
      mag64 = v[WIDE_BITS-1] ? (~v + 64'd1) : v;
   endfunction

endpackage

// File: design/mfa_div.sv
module mfa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mfa_pkg::div_cmd_type cmd,
   output mfa_pkg::div_sts_type sts
);
   import mfa_pkg::*;

   // unsigned restoring divider, one quotient bit a cycle
   logic [WIDE_BITS-1:0] quot_ff, quot_in;
   logic [WIDE_BITS-1:0] rem_ff, rem_in;
   logic [WIDE_BITS-1:0] dvs_ff, dvs_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WIDE_BITS:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[WIDE_BITS-1]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quot_in = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WIDE_BITS]) begin
            rem_in = trial[WIDE_BITS-1:0];
         end else begin
            rem_in = {rem_ff[WIDE_BITS-2:0], quot_ff[WIDE_BITS-1]};
         end
         quot_in = {quot_ff[WIDE_BITS-2:0], ~trial[WIDE_BITS]};
         cnt_in  = cnt_ff + 7'd1;
         if (cnt_ff == 7'(WIDE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign sts.done = done_ff;
   assign sts.quot = quot_ff;
   assign sts.rem  = rem_ff;

endmodule

// File: design/mfa_seq.sv
module mfa_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mfa_pkg::req_type     req_word,
   output logic                 busy,
   output logic                 rsp_valid,
   output mfa_pkg::rsp_type     rsp_word,
   output mfa_pkg::div_cmd_type div_cmd,
   input  mfa_pkg::div_sts_type div_sts
);
   import mfa_pkg::*;

   // improper numerators fit in twice the operand width
   localparam int MOP_BITS = 2 * OPERAND_BITS;

   typedef logic [WIDE_BITS-1:0] w_type;

   state_type  state_ff, state_in;
   req_type    req_ff, req_in;
   w_type      a_ff, a_in, b_ff, b_in;
   w_type      n_ff, n_in, d_ff, d_in, w_ff, w_in;
   w_type      x_ff, x_in;
   w_type      ga_ff, ga_in, gb_ff, gb_in;
   w_type      m_ff;
   logic       s_ff, s_in;
   logic       rneg_ff, rneg_in;
   gret_type   gret_ff, gret_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rv_ff, rv_in;

   w_type      wa, na, da, wb, nb, db;
   logic signed [MOP_BITS-1:0]  mop_a, mop_b;
   logic signed [WIDE_BITS-1:0] mprod;
   w_type      gr;

   function automatic w_type sx(input logic signed [OPERAND_BITS-1:0] v);
      sx = w_type'(v);
   endfunction

   assign wa = sx(req_ff.whole_a);
   assign na = sx(req_ff.numer_a);
   assign da = sx(req_ff.denom_a);
   assign wb = sx(req_ff.whole_b);
   assign nb = sx(req_ff.numer_b);
   assign db = sx(req_ff.denom_b);

   // shared multiplier, registered into m_ff
   always_comb begin
      mop_a = a_ff[MOP_BITS-1:0];
      mop_b = b_ff[MOP_BITS-1:0];
      unique case (state_ff)
         ST_DECODE: begin mop_a = da[MOP_BITS-1:0]; mop_b = wa[MOP_BITS-1:0]; end
         ST_IMPA:   begin mop_a = db[MOP_BITS-1:0]; mop_b = wb[MOP_BITS-1:0]; end
         ST_IMPB:   begin mop_a = db[MOP_BITS-1:0]; mop_b = a_ff[MOP_BITS-1:0]; end
         ST_X1:     begin mop_a = da[MOP_BITS-1:0]; mop_b = b_ff[MOP_BITS-1:0]; end
         ST_X2:     begin mop_a = da[MOP_BITS-1:0]; mop_b = db[MOP_BITS-1:0]; end
         ST_LCM_MUL: begin mop_a = wa[MOP_BITS-1:0]; mop_b = wb[MOP_BITS-1:0]; end
         default:   begin mop_a = a_ff[MOP_BITS-1:0]; mop_b = b_ff[MOP_BITS-1:0]; end
      endcase
   end
   assign mprod = mop_a * mop_b;

   always_ff @(posedge clock) begin
      m_ff <= mprod;
   end

   assign gr = rneg_ff ? (~div_sts.rem + 64'd1) : div_sts.rem;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      a_in = a_ff; b_in = b_ff; n_in = n_ff; d_in = d_ff; w_in = w_ff;
      x_in = x_ff; ga_in = ga_ff; gb_in = gb_ff; s_in = s_ff;
      rneg_in = rneg_ff; gret_in = gret_ff;
      rsp_in = rsp_ff;
      rv_in  = 1'b0;
      div_cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_word;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            // m_ff <= da*wa
            if (req_ff.opcode > 3'(OP_LCM)) begin
               rsp_in = '{48'sd0, 48'sd0, 48'sd1, ERR_OPCODE};
               state_in = ST_DONE;
            end else if (req_ff.opcode == 3'(OP_GCD)) begin
               x_in = wa; ga_in = wb; gret_in = GR_GCD;
               state_in = ST_GCD_INIT;
            end else if (req_ff.opcode == 3'(OP_LCM)) begin
               state_in = ST_LCM_MUL;
            end else if (da == '0 || db == '0) begin
               rsp_in = '{48'sd0, 48'sd0, 48'sd1, ERR_ZERO};
               state_in = ST_DONE;
            end else begin
               state_in = ST_IMPA;
            end
         end
         ST_IMPA: begin
            a_in = m_ff + na;
            state_in = ST_IMPB;
         end
         ST_IMPB: begin
            b_in = m_ff + nb;
            state_in = ST_X1;
         end
         ST_X1: begin
            x_in = m_ff;  // db*a
            state_in = ST_X2;
         end
         ST_X2: begin
            // m_ff = da*b
            unique case (req_ff.opcode)
               3'(OP_ADD): n_in = x_ff + m_ff;
               3'(OP_SUB): n_in = x_ff - m_ff;
               3'(OP_MUL): begin a_in = a_ff; b_in = b_ff; end
               default:    d_in = m_ff;
            endcase
            if (req_ff.opcode == 3'(OP_DIV)) n_in = x_ff;
            state_in = ST_X3;
         end
         ST_X3: begin
            // m_ff = da*db
            if (req_ff.opcode != 3'(OP_DIV)) d_in = m_ff;
            state_in = ST_X4;
         end
         ST_X4: begin
            // m_ff = a*b (default mux)
            if (req_ff.opcode == 3'(OP_MUL)) n_in = m_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (d_ff == '0) begin
               rsp_in = '{48'sd0, 48'sd0, 48'sd1, ERR_ZERO};
               state_in = ST_DONE;
            end else if (d_ff == 64'd1) begin
               rsp_in = '{n_ff[RES_BITS-1:0], 48'sd0, 48'sd1, ERR_NONE};
               state_in = ST_DONE;
            end else if (n_ff == '0) begin
               rsp_in = '{48'sd0, 48'sd0, 48'sd1, ERR_NONE};
               state_in = ST_DONE;
            end else begin
               s_in = n_ff[WIDE_BITS-1];
               n_in = mag64(n_ff);
               state_in = ST_WHOLE_DIV;
            end
         end
         ST_WHOLE_DIV: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = n_ff;
            div_cmd.divisor  = mag64(d_ff);
            rneg_in = n_ff[WIDE_BITS-1];
            state_in = ST_WHOLE_WAIT;
         end
         ST_WHOLE_WAIT: begin
            if (div_sts.done) begin
               // quotient sign from n (may be negative after wrap) and d
               if (n_ff[WIDE_BITS-1] != d_ff[WIDE_BITS-1])
                  w_in = ~div_sts.quot + 64'd1;
               else
                  w_in = div_sts.quot;
               // n - w*d is the remainder of |n| / |d|
               n_in = div_sts.rem;
               state_in = ST_WHOLE_FIX;
            end
         end
         ST_WHOLE_FIX: begin
            w_in = s_ff ? (~w_ff + 64'd1) : w_ff;
            state_in = ST_RED_DIV2;
         end
         ST_RED_DIV2: begin
            if (n_ff == '0) begin
               rsp_in = '{w_ff[RES_BITS-1:0], 48'sd0, 48'sd1, ERR_NONE};
               state_in = ST_DONE;
            end else begin
               x_in = n_ff; ga_in = d_ff; gret_in = GR_RED;
               state_in = ST_GCD_INIT;
            end
         end
         ST_GCD_INIT: begin
            // order: ga = smaller, gb = larger (signed)
            if ($signed(x_ff) <= $signed(ga_ff)) begin
               ga_in = x_ff; gb_in = ga_ff;
            end else begin
               ga_in = ga_ff; gb_in = x_ff;
            end
            state_in = ST_GCD_DIV;
         end
         ST_GCD_DIV: begin
            if (ga_ff == '0) begin
               if (gb_ff == '0) gb_in = 64'd1;
               state_in = ST_LCM_DIV;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = mag64(gb_ff);
               div_cmd.divisor  = mag64(ga_ff);
               rneg_in = gb_ff[WIDE_BITS-1];
               state_in = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (div_sts.done) begin
               gb_in = ga_ff;
               ga_in = gr;
               state_in = ST_GCD_DIV;
            end
         end
         ST_LCM_MUL: begin
            x_in = wa; ga_in = wb; gret_in = GR_LCM;
            b_in = mprod;
            state_in = ST_GCD_INIT;
         end
         ST_LCM_DIV: begin
            // gcd result in gb_ff
            unique case (gret_ff)
               GR_GCD: begin
                  rsp_in = '{gb_ff[RES_BITS-1:0], 48'sd0, 48'sd1, ERR_NONE};
                  state_in = ST_DONE;
               end
               GR_LCM: begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = mag64(b_ff);
                  div_cmd.divisor  = mag64(gb_ff);
                  state_in = ST_LCM_WAIT;
               end
               default: begin
                  if ($signed(gb_ff) > 64'sd1) begin
                     div_cmd.start    = 1'b1;
                     div_cmd.dividend = mag64(n_ff);
                     div_cmd.divisor  = gb_ff;
                     gret_in = GR_GCD;
                     state_in = ST_LCM_WAIT;
                  end else begin
                     // no reduction: emit straight from RED_WAIT2
                     n_in = s_ff ? (~n_ff + 64'd1) : n_ff;
                     gret_in = GR_GCD;
                     state_in = ST_RED_WAIT2;
                  end
               end
            endcase
         end
         ST_LCM_WAIT: begin
            if (div_sts.done) begin
               if (gret_ff == GR_LCM) begin
                  if (b_ff[WIDE_BITS-1] != gb_ff[WIDE_BITS-1])
                     x_in = ~div_sts.quot + 64'd1;
                  else
                     x_in = div_sts.quot;
                  rsp_in = '{x_in[RES_BITS-1:0], 48'sd0, 48'sd1, ERR_NONE};
                  state_in = ST_DONE;
               end else begin
                  // n/g done; n is nonnegative, g>1
                  n_in = div_sts.quot;
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = mag64(d_ff);
                  div_cmd.divisor  = gb_ff;
                  rneg_in = d_ff[WIDE_BITS-1];
                  state_in = ST_RED_WAIT2;
                  gret_in = GR_RED;
               end
            end
         end
         ST_RED_WAIT2: begin
            if (gret_ff == GR_RED) begin
               if (div_sts.done) begin
                  d_in = rneg_ff ? (~div_sts.quot + 64'd1) : div_sts.quot;
                  n_in = s_ff ? (~n_ff + 64'd1) : n_ff;
                  gret_in = GR_GCD;
               end
            end else begin
               rsp_in = '{w_ff[RES_BITS-1:0], n_ff[RES_BITS-1:0],
                          d_ff[RES_BITS-1:0], ERR_NONE};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         gret_ff  <= GR_GCD;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         gret_ff  <= gret_in;
      end
      req_ff <= req_in;
      a_ff <= a_in; b_ff <= b_in; n_ff <= n_in; d_ff <= d_in; w_ff <= w_in;
      x_ff <= x_in; ga_ff <= ga_in; gb_ff <= gb_in; s_ff <= s_in;
      rneg_ff <= rneg_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_word  = rsp_ff;

endmodule

// File: design/mixed_fraction_alu_core.sv
// An unknown opcode or a zero denominator finishes without the divider; a long Euclid
// run takes longest, as each divide on the shared radix-2 divider (whole part,
// each Euclid remainder step, reduction) runs a full division there.
// Throughput: one word at a time; busy drops in the result strobe cycle.
// Reset: synchronous, active high; clears the sequencer to idle.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
module mixed_fraction_alu_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mfa_pkg::req_type req_word,
   output logic             rsp_valid,
   output mfa_pkg::rsp_type rsp_word
);
   import mfa_pkg::*;

   div_cmd_type div_cmd;
   div_sts_type div_sts;

   mfa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .div_cmd   (div_cmd),
      .div_sts   (div_sts)
   );

   mfa_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

endmodule
